/* design/hcbd_pkg.sv */
// Shared types, character constants and codes of the chunked body decoder.
package hcbd_pkg;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7f;

   localparam logic [1:0] CSR_LINE_MODE = 2'd0;
   localparam logic [1:0] CSR_MAX_LINE  = 2'd1;
   localparam logic [1:0] CSR_MAX_TOTAL = 2'd2;

   localparam logic        LINE_MODE_RESET = 1'b1;
   localparam logic [15:0] MAX_LINE_RESET  = 16'd8192;
   localparam logic [15:0] MAX_TOTAL_RESET = 16'd32768;

   typedef enum logic [1:0] {
      KIND_SILENT,
      KIND_PAYLOAD,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_SIZE_DIGIT,
      ERR_SIZE_OVERFLOW,
      ERR_CHUNK_BREAK,
      ERR_TRAILER,
      ERR_TRAILER_LONG
   } err_type;

   typedef struct packed {
      logic        line_mode;
      logic [15:0] max_line;
      logic [15:0] max_total;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
      err_type    fault_code;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type    h;
      logic [7:0] d;
      h = '0;
      d = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         h.valid = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         h.valid = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         h.valid = 1'b1;
      end
      h.value = d[3:0];
      return h;
   endfunction

endpackage

/* design/hcbd_in_reg.sv */
// Input register that holds one request until the decoder core takes it.
module hcbd_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  hcbd_pkg::item_type  req_item,
   input  logic                pop,
   output logic                item_valid,
   output hcbd_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   hcbd_pkg::item_type item_ff;
   logic               accept;

   assign req_tready = !valid_ff || pop;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !pop);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

/* design/hcbd_core.sv */
// Decoder state machine with the registered result stage.
module hcbd_core #(
   parameter int CHUNK_SIZE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hcbd_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  hcbd_pkg::item_type   item,
   output logic                 pop,
   input  logic                 out_ready,
   output logic                 out_valid,
   output hcbd_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_SIZE_FIRST,
      PH_SIZE_MORE,
      PH_SIZE_EXT,
      PH_SIZE_CR,
      PH_DATA,
      PH_BRK,
      PH_BRK_LF,
      PH_TR_LINE,
      PH_TR_CR,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic        fail;
      logic [15:0] len;
      logic        colon;
      logic        bad;
   } line_type;

   function automatic line_type tr_content(input line_type s, input logic [7:0] c,
                                           input logic [15:0] max_line);
      line_type    r;
      logic [16:0] len1;
      r = s;
      r.fail = 1'b0;
      len1 = {1'b0, s.len} + 17'd1;
      if (len1 > {1'b0, max_line}) begin
         r.fail = 1'b1;
      end else begin
         r.len = len1[15:0];
         if (!s.colon) begin
            if (c == hcbd_pkg::CH_COLON) begin
               r.colon = 1'b1;
               if (len1 == 17'd1) begin
                  r.bad = 1'b1;
               end
            end
         end else if ((c < hcbd_pkg::CH_SPACE && c != hcbd_pkg::CH_TAB) ||
                      c == hcbd_pkg::CH_DEL) begin
            r.bad = 1'b1;
         end
      end
      return r;
   endfunction

   phase_type                  phase_ff, phase_in;
   logic [CHUNK_SIZE_BITS-1:0] rem_ff, rem_in;
   logic [15:0]                len_ff, len_in;
   logic [15:0]                tot_ff, tot_in;
   logic                       colon_ff, colon_in;
   logic                       bad_ff, bad_in;
   hcbd_pkg::err_type          err_ff, err_in;
   logic                       out_valid_ff, out_valid_in;
   hcbd_pkg::result_type       result_ff, result_in;

   logic [7:0]                 c;
   hcbd_pkg::hex_type          hex;
   line_type                   cur, cr_step, tb_src, tb_content, tr_line, end_src;
   logic                       tr_end, tr_fail;
   phase_type                  tr_phase;
   logic [16:0]                sum;
   logic                       size_end_now, fail_now;
   hcbd_pkg::err_type          fail_cause;
   hcbd_pkg::kind_type         kind;
   logic [7:0]                 pay;
   logic                       crlf_here;

   assign pop          = item_valid && (!out_valid_ff || out_ready);
   assign out_valid_in = pop || (out_valid_ff && !out_ready);
   assign out_valid    = out_valid_ff;
   assign result       = result_ff;

   assign c         = item.data_byte;
   assign hex       = hcbd_pkg::hex_digit(c);
   assign crlf_here = (phase_ff == PH_TR_CR) && (c == hcbd_pkg::CH_LF);

   always_comb begin
      cur        = '{fail: 1'b0, len: len_ff, colon: colon_ff, bad: bad_ff};
      cr_step    = tr_content(cur, hcbd_pkg::CH_CR, cfg.max_line);
      tb_src     = (phase_ff == PH_TR_CR) ? cr_step : cur;
      tb_src.fail = 1'b0;
      tb_content = tr_content(tb_src, c, cfg.max_line);
      end_src    = crlf_here ? cur : tb_src;
      sum        = {1'b0, tot_ff} + {1'b0, end_src.len};

      tr_end   = 1'b0;
      tr_fail  = 1'b0;
      tr_phase = PH_TR_LINE;
      tr_line  = tb_src;
      if (crlf_here) begin
         tr_end = 1'b1;
      end else if (phase_ff == PH_TR_CR && cr_step.fail) begin
         tr_fail = 1'b1;
      end else if (cfg.line_mode && c == hcbd_pkg::CH_CR) begin
         tr_phase = PH_TR_CR;
      end else if (!cfg.line_mode && c == hcbd_pkg::CH_LF) begin
         tr_end = 1'b1;
      end else begin
         tr_line = tb_content;
         tr_fail = tb_content.fail;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      tot_in       = tot_ff;
      colon_in     = colon_ff;
      bad_in       = bad_ff;
      err_in       = err_ff;
      kind         = hcbd_pkg::KIND_SILENT;
      pay          = '0;
      size_end_now = 1'b0;
      fail_now     = 1'b0;
      fail_cause   = hcbd_pkg::ERR_NONE;

      case (phase_ff)
         PH_SIZE_FIRST, PH_SIZE_MORE: begin
            if (cfg.line_mode && c == hcbd_pkg::CH_CR) begin
               if (phase_ff == PH_SIZE_FIRST) begin
                  fail_now   = 1'b1;
                  fail_cause = hcbd_pkg::ERR_SIZE_DIGIT;
               end else begin
                  phase_in = PH_SIZE_CR;
               end
            end else if (!cfg.line_mode && c == hcbd_pkg::CH_LF) begin
               if (phase_ff == PH_SIZE_FIRST) begin
                  fail_now   = 1'b1;
                  fail_cause = hcbd_pkg::ERR_SIZE_DIGIT;
               end else begin
                  size_end_now = 1'b1;
               end
            end else if (c == hcbd_pkg::CH_SEMI) begin
               if (phase_ff == PH_SIZE_FIRST) begin
                  fail_now   = 1'b1;
                  fail_cause = hcbd_pkg::ERR_SIZE_DIGIT;
               end else begin
                  phase_in = PH_SIZE_EXT;
               end
            end else if (!hex.valid) begin
               fail_now   = 1'b1;
               fail_cause = hcbd_pkg::ERR_SIZE_DIGIT;
            end else if (rem_ff[CHUNK_SIZE_BITS-1 -: 4] != 4'd0) begin
               fail_now   = 1'b1;
               fail_cause = hcbd_pkg::ERR_SIZE_OVERFLOW;
            end else begin
               rem_in   = {rem_ff[CHUNK_SIZE_BITS-5:0], hex.value};
               phase_in = PH_SIZE_MORE;
            end
         end
         PH_SIZE_EXT: begin
            if (cfg.line_mode && c == hcbd_pkg::CH_CR) begin
               phase_in = PH_SIZE_CR;
            end else if (!cfg.line_mode && c == hcbd_pkg::CH_LF) begin
               size_end_now = 1'b1;
            end
         end
         PH_SIZE_CR: begin
            if (c == hcbd_pkg::CH_LF) begin
               size_end_now = 1'b1;
            end else begin
               fail_now   = 1'b1;
               fail_cause = hcbd_pkg::ERR_SIZE_DIGIT;
            end
         end
         PH_DATA: begin
            kind   = hcbd_pkg::KIND_PAYLOAD;
            pay    = c;
            rem_in = rem_ff - CHUNK_SIZE_BITS'(1);
            if (rem_ff == CHUNK_SIZE_BITS'(1)) begin
               phase_in = PH_BRK;
            end
         end
         PH_BRK: begin
            if (cfg.line_mode) begin
               if (c == hcbd_pkg::CH_CR) begin
                  phase_in = PH_BRK_LF;
               end else begin
                  fail_now   = 1'b1;
                  fail_cause = hcbd_pkg::ERR_CHUNK_BREAK;
               end
            end else if (c == hcbd_pkg::CH_LF) begin
               rem_in   = '0;
               phase_in = PH_SIZE_FIRST;
            end else begin
               fail_now   = 1'b1;
               fail_cause = hcbd_pkg::ERR_CHUNK_BREAK;
            end
         end
         PH_BRK_LF: begin
            if (c == hcbd_pkg::CH_LF) begin
               rem_in   = '0;
               phase_in = PH_SIZE_FIRST;
            end else begin
               fail_now   = 1'b1;
               fail_cause = hcbd_pkg::ERR_CHUNK_BREAK;
            end
         end
         PH_TR_LINE, PH_TR_CR: begin
            if (tr_fail) begin
               fail_now   = 1'b1;
               fail_cause = hcbd_pkg::ERR_TRAILER_LONG;
            end else if (tr_end) begin
               if (end_src.len == 16'd0) begin
                  phase_in = PH_DONE;
                  kind     = hcbd_pkg::KIND_DONE;
               end else if (sum > {1'b0, cfg.max_total}) begin
                  fail_now   = 1'b1;
                  fail_cause = hcbd_pkg::ERR_TRAILER_LONG;
               end else if (end_src.bad || !end_src.colon) begin
                  fail_now   = 1'b1;
                  fail_cause = hcbd_pkg::ERR_TRAILER;
               end else begin
                  tot_in   = sum[15:0];
                  len_in   = '0;
                  colon_in = 1'b0;
                  bad_in   = 1'b0;
                  phase_in = PH_TR_LINE;
               end
            end else begin
               phase_in = tr_phase;
               len_in   = tr_line.len;
               colon_in = tr_line.colon;
               bad_in   = tr_line.bad;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERROR;
            kind     = hcbd_pkg::KIND_ERROR;
         end
      endcase

      if (size_end_now) begin
         if (rem_ff == '0) begin
            tot_in   = '0;
            len_in   = '0;
            colon_in = 1'b0;
            bad_in   = 1'b0;
            phase_in = PH_TR_LINE;
         end else begin
            phase_in = PH_DATA;
         end
      end

      if (fail_now) begin
         phase_in = PH_ERROR;
         err_in   = fail_cause;
         kind     = hcbd_pkg::KIND_ERROR;
      end

      if (item.restart) begin
         phase_in = PH_SIZE_FIRST;
         rem_in   = '0;
         len_in   = '0;
         tot_in   = '0;
         colon_in = 1'b0;
         bad_in   = 1'b0;
         err_in   = hcbd_pkg::ERR_NONE;
         kind     = hcbd_pkg::KIND_SILENT;
      end

      result_in.kind       = kind;
      result_in.payload    = (kind == hcbd_pkg::KIND_PAYLOAD) ? pay : 8'd0;
      result_in.fault_code = (kind == hcbd_pkg::KIND_ERROR) ? err_in : hcbd_pkg::ERR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE_FIRST;
         rem_ff       <= '0;
         len_ff       <= '0;
         tot_ff       <= '0;
         colon_ff     <= 1'b0;
         bad_ff       <= 1'b0;
         err_ff       <= hcbd_pkg::ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            rem_ff   <= rem_in;
            len_ff   <= len_in;
            tot_ff   <= tot_in;
            colon_ff <= colon_in;
            bad_ff   <= bad_in;
            err_ff   <= err_in;
         end
      end
      if (pop) begin
         result_ff <= result_in;
      end
   end

endmodule

/* design/http_chunked_body_decoder.sv */
// Top level of the HTTP chunked body decoder with its control registers.
//
//   channel   direction  contents
//   req_*     in         tdata: data_byte[7:0]; tuser: restart[0]
//   rsp_*     out        tdata: payload[7:0], fault_code[10:8]; tuser: kind[1:0]
//   csr_*     in         write enable, register index, write data
//
// One byte is decoded per clock unless the result side stalls; each request yields
// one result, held in the input register and presented from the result register.
// A new request is taken each cycle while the result side keeps up, and one more
// while a finished result waits. Reset is synchronous and restores the register
// defaults and the state that awaits the first size line.
module http_chunked_body_decoder #(
   parameter int CHUNK_SIZE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [0:0]  req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // payload, fault_code, zero fill
   output logic [1:0]  rsp_tuser,   // kind
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   hcbd_pkg::cfg_type    cfg_ff;
   hcbd_pkg::item_type   req_item;
   hcbd_pkg::item_type   item;
   hcbd_pkg::result_type result;
   logic                 item_valid;
   logic                 pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_mode <= hcbd_pkg::LINE_MODE_RESET;
         cfg_ff.max_line  <= hcbd_pkg::MAX_LINE_RESET;
         cfg_ff.max_total <= hcbd_pkg::MAX_TOTAL_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            hcbd_pkg::CSR_LINE_MODE: cfg_ff.line_mode <= csr_wdata[0];
            hcbd_pkg::CSR_MAX_LINE:  cfg_ff.max_line  <= csr_wdata;
            hcbd_pkg::CSR_MAX_TOTAL: cfg_ff.max_total <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_item.data_byte = req_tdata;
   assign req_item.restart   = req_tuser[0];

   hcbd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   hcbd_core #(
      .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .pop        (pop),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .result     (result)
   );

   assign rsp_tdata = {5'd0, result.fault_code, result.payload};
   assign rsp_tuser = result.kind;

   a_error_has_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result.kind == hcbd_pkg::KIND_ERROR) |->
         result.fault_code != hcbd_pkg::ERR_NONE)
      else $error("Error result carries no cause.");

   a_payload_only_on_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result.kind != hcbd_pkg::KIND_PAYLOAD) |-> result.payload == 8'd0)
      else $error("Payload set on a result that is not a payload byte.");

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !pop) |=> item_valid)
      else $error("A held request was dropped.");

   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_tvalid)
      else $error("A decoded request produced no result.");

endmodule

/* test/tb.sv */
// Self-checking testbench for the HTTP chunked body decoder with a built-in predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hcbd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SEG_ITEMS = 70;

   typedef enum logic [3:0] {
      P_SIZE_FIRST,
      P_SIZE_MORE,
      P_SIZE_EXT,
      P_SIZE_CR,
      P_DATA,
      P_BRK,
      P_BRK_LF,
      P_TR_LINE,
      P_TR_CR,
      P_DONE,
      P_ERROR
   } dec_phase_type;

   // A request as offered; pinned rows carry a result that is known by inspection.
   typedef struct {
      logic [7:0] data;
      logic       restart;
      logic       pinned;
      result_type pin;
   } req_type;

   localparam result_type NO_PIN = '{KIND_SILENT, 8'h00, ERR_NONE};
   localparam result_type PIN_SILENT = '{KIND_SILENT, 8'h00, ERR_NONE};
   localparam result_type PIN_BAD_DIGIT = '{KIND_ERROR, 8'h00, ERR_SIZE_DIGIT};
   localparam result_type PIN_OVERFLOW = '{KIND_ERROR, 8'h00, ERR_SIZE_OVERFLOW};
   localparam result_type PIN_DONE = '{KIND_DONE, 8'h00, ERR_NONE};

   localparam cfg_type SEG_CFG [1:7] = '{
      '{1'b0, 16'hffff, 16'hffff},
      '{1'b1, 16'd1, 16'd1},
      '{1'b0, 16'd8, 16'd12},
      '{1'b1, 16'hffff, 16'hffff},
      '{1'b1, 16'd10, 16'd16},
      '{1'b0, 16'd1, 16'hffff},
      '{1'b1, 16'd20, 16'd1}
   };

   req_type dir_rows [28] = '{
      '{8'h00, 1'b1, 1'b1, PIN_SILENT},
      '{CH_SEMI, 1'b0, 1'b1, PIN_BAD_DIGIT},
      '{8'hff, 1'b0, 1'b1, PIN_BAD_DIGIT},
      '{8'hff, 1'b1, 1'b1, PIN_SILENT},
      '{"2", 1'b0, 1'b0, NO_PIN},
      '{CH_CR, 1'b0, 1'b0, NO_PIN},
      '{CH_LF, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b1, '{KIND_PAYLOAD, 8'h00, ERR_NONE}},
      '{8'hff, 1'b0, 1'b1, '{KIND_PAYLOAD, 8'hff, ERR_NONE}},
      '{CH_CR, 1'b0, 1'b0, NO_PIN},
      '{CH_LF, 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{CH_CR, 1'b0, 1'b0, NO_PIN},
      '{CH_LF, 1'b0, 1'b0, NO_PIN},
      '{CH_CR, 1'b0, 1'b0, NO_PIN},
      '{CH_LF, 1'b0, 1'b1, PIN_DONE},
      '{"z", 1'b0, 1'b1, PIN_SILENT},
      '{8'h00, 1'b1, 1'b1, PIN_SILENT},
      '{"1", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b0, NO_PIN},
      '{"0", 1'b0, 1'b1, PIN_OVERFLOW},
      '{8'h00, 1'b1, 1'b1, PIN_SILENT}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   req_type     stim_q [$];
   result_type  result_q [$];
   logic [7:0]  body_q [$];
   req_type     in_flight;
   logic        req_taken;
   int unsigned fail_count;
   int unsigned cycle_count;

   logic          cfg_line_mode;
   int unsigned   cfg_max_line;
   int unsigned   cfg_max_total;
   dec_phase_type dec_phase;
   logic [31:0]   chunk_left;
   int unsigned   line_len;
   int unsigned   trailer_sum;
   logic          colon_seen;
   logic          line_bad;
   err_type       err_code;

   http_chunked_body_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic kind_type raise_error(err_type cause);
      dec_phase = P_ERROR;
      err_code = cause;
      return KIND_ERROR;
   endfunction

   function automatic void open_trailer_line();
      line_len = 0;
      colon_seen = 1'b0;
      line_bad = 1'b0;
   endfunction

   function automatic kind_type take_trailer_char(logic [7:0] c);
      int unsigned len;
      len = line_len + 1;
      if (len > cfg_max_line) return raise_error(ERR_TRAILER_LONG);
      line_len = len;
      if (!colon_seen) begin
         if (c == CH_COLON) begin
            colon_seen = 1'b1;
            if (len == 1) line_bad = 1'b1;
         end
      end else if ((c < CH_SPACE && c != CH_TAB) || c == CH_DEL) begin
         line_bad = 1'b1;
      end
      return KIND_SILENT;
   endfunction

   function automatic kind_type close_trailer_line();
      int unsigned total;
      if (line_len == 0) begin
         dec_phase = P_DONE;
         return KIND_DONE;
      end
      total = trailer_sum + line_len;
      if (total > cfg_max_total) return raise_error(ERR_TRAILER_LONG);
      if (line_bad || !colon_seen) return raise_error(ERR_TRAILER);
      trailer_sum = total;
      open_trailer_line();
      dec_phase = P_TR_LINE;
      return KIND_SILENT;
   endfunction

   function automatic kind_type take_trailer_byte(logic [7:0] c);
      if (cfg_line_mode) begin
         if (c == CH_CR) begin
            dec_phase = P_TR_CR;
            return KIND_SILENT;
         end
      end else if (c == CH_LF) begin
         return close_trailer_line();
      end
      return take_trailer_char(c);
   endfunction

   function automatic kind_type end_size_line();
      if (chunk_left == 0) begin
         trailer_sum = 0;
         open_trailer_line();
         dec_phase = P_TR_LINE;
      end else begin
         dec_phase = P_DATA;
      end
      return KIND_SILENT;
   endfunction

   function automatic void clear_decoder();
      dec_phase = P_SIZE_FIRST;
      chunk_left = '0;
      trailer_sum = 0;
      open_trailer_line();
      err_code = ERR_NONE;
   endfunction

   function automatic result_type decode_request(logic [7:0] c, logic restart);
      result_type r;
      kind_type   k;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       first;
      k = KIND_SILENT;
      hex_ok = 1'b1;
      hex_val = '0;
      if (c >= "0" && c <= "9") hex_val = 4'(c - "0");
      else if (c >= "a" && c <= "f") hex_val = 4'(c - "a" + 10);
      else if (c >= "A" && c <= "F") hex_val = 4'(c - "A" + 10);
      else hex_ok = 1'b0;
      first = (dec_phase == P_SIZE_FIRST);
      if (restart) begin
         clear_decoder();
      end else begin
         case (dec_phase)
            P_SIZE_FIRST, P_SIZE_MORE: begin
               if (cfg_line_mode && c == CH_CR) begin
                  if (first) k = raise_error(ERR_SIZE_DIGIT);
                  else dec_phase = P_SIZE_CR;
               end else if (!cfg_line_mode && c == CH_LF) begin
                  if (first) k = raise_error(ERR_SIZE_DIGIT);
                  else k = end_size_line();
               end else if (c == CH_SEMI) begin
                  if (first) k = raise_error(ERR_SIZE_DIGIT);
                  else dec_phase = P_SIZE_EXT;
               end else if (!hex_ok) begin
                  k = raise_error(ERR_SIZE_DIGIT);
               end else if (chunk_left[31:28] != 4'd0) begin
                  k = raise_error(ERR_SIZE_OVERFLOW);
               end else begin
                  chunk_left = {chunk_left[27:0], hex_val};
                  dec_phase = P_SIZE_MORE;
               end
            end
            P_SIZE_EXT: begin
               if (cfg_line_mode && c == CH_CR) dec_phase = P_SIZE_CR;
               else if (!cfg_line_mode && c == CH_LF) k = end_size_line();
            end
            P_SIZE_CR: begin
               if (c == CH_LF) k = end_size_line();
               else k = raise_error(ERR_SIZE_DIGIT);
            end
            P_DATA: begin
               k = KIND_PAYLOAD;
               chunk_left = chunk_left - 1;
               if (chunk_left == 0) dec_phase = P_BRK;
            end
            P_BRK: begin
               if (cfg_line_mode) begin
                  if (c == CH_CR) dec_phase = P_BRK_LF;
                  else k = raise_error(ERR_CHUNK_BREAK);
               end else if (c == CH_LF) begin
                  chunk_left = '0;
                  dec_phase = P_SIZE_FIRST;
               end else begin
                  k = raise_error(ERR_CHUNK_BREAK);
               end
            end
            P_BRK_LF: begin
               if (c == CH_LF) begin
                  chunk_left = '0;
                  dec_phase = P_SIZE_FIRST;
               end else begin
                  k = raise_error(ERR_CHUNK_BREAK);
               end
            end
            P_TR_LINE: k = take_trailer_byte(c);
            P_TR_CR: begin
               if (c == CH_LF) begin
                  k = close_trailer_line();
               end else begin
                  dec_phase = P_TR_LINE;
                  k = take_trailer_char(CH_CR);
                  if (k == KIND_SILENT) k = take_trailer_byte(c);
               end
            end
            P_DONE: k = KIND_SILENT;
            default: begin
               dec_phase = P_ERROR;
               k = KIND_ERROR;
            end
         endcase
      end
      r.kind = k;
      r.payload = (k == KIND_PAYLOAD) ? c : 8'h00;
      r.fault_code = (k == KIND_ERROR) ? err_code : ERR_NONE;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(int unsigned nib);
      if (nib < 10) return 8'("0" + nib);
      if ($urandom_range(1) == 1) return 8'("a" + nib - 10);
      return 8'("A" + nib - 10);
   endfunction

   function automatic void add_byte(logic [7:0] b);
      body_q.insert(body_q.size(), b);
   endfunction

   function automatic void queue_request(req_type q);
      stim_q.insert(stim_q.size(), q);
   endfunction

   function automatic void add_break();
      if (cfg_line_mode) add_byte(CH_CR);
      add_byte(CH_LF);
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_CR || b == CH_LF) b = "x";
      return b;
   endfunction

   // Builds one chunked body, mostly well formed, and queues it behind a restart.
   function automatic void append_body();
      int unsigned chunks, len, digits, lines, nlen, vlen, pick, cut;
      logic [7:0]  b;
      body_q.delete();
      chunks = $urandom_range(3);
      for (int i = 0; i <= chunks; i++) begin
         if (i == chunks) len = 0;
         else if ($urandom_range(9) == 0) len = $urandom_range(40, 1);
         else len = $urandom_range(6, 1);
         if ($urandom_range(24) == 0) begin
            add_byte(hex_char($urandom_range(15, 1)));
            repeat (8) add_byte(hex_char($urandom_range(15)));
         end
         repeat ($urandom_range(2)) add_byte("0");
         digits = 1;
         while (digits < 8 && (len >> (4 * digits)) != 0) digits++;
         for (int j = digits - 1; j >= 0; j--) add_byte(hex_char((len >> (4 * j)) & 15));
         if ($urandom_range(3) == 0) begin
            add_byte(CH_SEMI);
            repeat ($urandom_range(3)) add_byte(plain_byte());
         end
         add_break();
         if (len != 0) begin
            repeat (len) add_byte(8'($urandom_range(255)));
            add_break();
         end
      end
      lines = $urandom_range(2);
      repeat (lines) begin
         nlen = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
         repeat (nlen) add_byte(8'("A" + $urandom_range(25) + 32 * $urandom_range(1)));
         if ($urandom_range(11) != 0) add_byte(CH_COLON);
         vlen = $urandom_range(6);
         repeat (vlen) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
               b = 8'($urandom_range(31));
               if (b == CH_CR || b == CH_LF) b = CH_DEL;
            end else if (pick == 1) begin
               b = CH_TAB;
            end else begin
               b = 8'($urandom_range(8'h7e, 8'h20));
            end
            add_byte(b);
         end
         add_break();
      end
      add_break();
      repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
      if ($urandom_range(5) == 0) body_q[$urandom_range(body_q.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(body_q.size() - 1);
         while (body_q.size() > cut) void'(body_q.pop_back());
      end
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(4, 1))
            queue_request('{8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0, NO_PIN});
      end
      queue_request('{8'($urandom_range(255)), 1'b1, 1'b0, NO_PIN});
      foreach (body_q[i]) queue_request('{body_q[i], 1'b0, 1'b0, NO_PIN});
   endfunction

   task automatic program_regs(cfg_type c);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_LINE_MODE;
      csr_wdata <= {15'd0, c.line_mode};
      @(negedge clock);
      csr_addr <= CSR_MAX_LINE;
      csr_wdata <= c.max_line;
      @(negedge clock);
      csr_addr <= CSR_MAX_TOTAL;
      csr_wdata <= c.max_total;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_line_mode = c.line_mode;
      cfg_max_line = c.max_line;
      cfg_max_total = c.max_total;
   endtask

   task automatic play_requests(int unsigned idle_mode);
      int unsigned gap_pct, stall_pct;
      logic        offering;
      gap_pct = (idle_mode == 1) ? 53 : (idle_mode == 3) ? 23 : 0;
      stall_pct = (idle_mode == 2) ? 53 : (idle_mode == 3) ? 23 : 0;
      offering = 1'b0;
      req_taken = 1'b0;
      while (stim_q.size() > 0 || offering || result_q.size() > 0) begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (req_taken) begin
            offering = 1'b0;
            req_taken = 1'b0;
         end
         if (!offering) begin
            if (stim_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
               in_flight = stim_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= in_flight.data;
               req_tuser <= in_flight.restart;
               offering = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
      @(negedge clock);
      rsp_tready <= 1'b1;
      repeat (3) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = decode_request(in_flight.data, in_flight.restart);
            if (in_flight.pinned) want = in_flight.pin;
            result_q.insert(result_q.size(), want);
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $error("result arrived with no request outstanding");
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[7:0] !== want.payload) begin
                  $error("payload: expected %0h, actual %0h", want.payload, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[10:8] !== want.fault_code) begin
                  $error("fault_code: expected %0d, actual %0d", want.fault_code,
                         rsp_tdata[10:8]);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      fail_count = 0;
      cycle_count = 0;
      req_taken = 1'b0;
      cfg_line_mode = LINE_MODE_RESET;
      cfg_max_line = MAX_LINE_RESET;
      cfg_max_total = MAX_TOTAL_RESET;
      clear_decoder();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rsp_tready <= 1'b1;

      foreach (dir_rows[i]) queue_request(dir_rows[i]);
      play_requests(0);

      for (int seg = 1; seg <= 7; seg++) begin
         program_regs(SEG_CFG[seg]);
         while (stim_q.size() < SEG_ITEMS) append_body();
         play_requests(seg % 4);
      end

      repeat (8) @(posedge clock);
      if (result_q.size() != 0) begin
         $error("%0d results never arrived", result_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* http_chunked_body_decoder.f */
design/hcbd_pkg.sv
design/hcbd_in_reg.sv
design/hcbd_core.sv
design/http_chunked_body_decoder.sv
test/tb.sv
